[src/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;
  localparam int KEY_W  = 8;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    KIND_PUSH      = 2'd0,
    KIND_POP_HEAD  = 2'd1,
    KIND_POP_EXACT = 2'd2,
    KIND_POP_MIN   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DATA_W-1:0]  entry_data;
    logic        [KEY_W-1:0]   prio_key;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  out_data;
    logic        [KEY_W-1:0]   out_priority;
    logic        [FILL_W-1:0]  fill_count;
  } out_item_t;

  typedef struct packed {
    logic                      vld;
    logic        [KEY_W-1:0]   prio;
    logic signed [DATA_W-1:0]  data;
  } entry_t;

  typedef struct packed {
    logic                      push;
    logic                      pop_head;
    logic                      pop_exact;
    logic        [KEY_W-1:0]   key;
    logic signed [DATA_W-1:0]  data;
  } cell_cmd_t;

endpackage

[src/spq_cell.sv]
// One slot of the sorted queue, shifting entries to and from its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_cmd_t                cmd,
  input  entry_t                   left_ent,
  input  logic                     left_ge,
  input  logic                     left_eq,
  input  entry_t                   right_ent,
  output entry_t                   ent,
  output logic                     ge_key,
  output logic                     eq_key,
  output logic signed [DATA_W-1:0] taken_data
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   le_key;

  assign ge_key     = ent_r.vld && (ent_r.prio >= cmd.key);
  assign le_key     = ent_r.vld && (ent_r.prio <= cmd.key);
  assign eq_key     = ent_r.vld && (ent_r.prio == cmd.key);
  assign taken_data = (eq_key && !left_eq) ? ent_r.data : '0;
  assign ent        = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.push) begin
      if (!ge_key) begin
        if (left_ge) begin
          ent_nxt.vld  = 1'b1;
          ent_nxt.prio = cmd.key;
          ent_nxt.data = cmd.data;
        end else begin
          ent_nxt = left_ent;
        end
      end
    end else if (cmd.pop_head) begin
      ent_nxt = right_ent;
    end else if (cmd.pop_exact) begin
      if (le_key) begin
        ent_nxt = right_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.prio <= ent_nxt.prio;
    ent_r.data <= ent_nxt.data;
  end

endmodule

[src/stable_priority_queue.sv]
// Top level of the stable sorted priority queue built from a row of cells.
//
//   channel  ports                       handshake
//   input    start, busy, in_item        taken when start is high and busy is low
//   result   out_strobe, out_result      one strobe per item, cannot be held off
//
// Busy stays low, so a new item may follow in the next cycle. The result is
// registered and appears in the cycle after the item is taken.
// All cells compare against the key in parallel and shift in the same cycle.
// Reset clears the valid bit of each cell and the fill count.
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_result
);

  entry_t                   ent_w   [DEPTH];
  logic signed [DATA_W-1:0] taken_w [DEPTH];
  logic        [DEPTH-1:0]  ge_v;
  logic        [DEPTH-1:0]  eq_v;

  cell_cmd_t                cmd;
  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     found;
  logic signed [DATA_W-1:0] exact_data;

  logic        [CNT_W-1:0]  cnt_r;
  logic        [CNT_W-1:0]  cnt_nxt;
  logic                     out_strobe_r;
  out_item_t                out_result_r;
  out_item_t                res_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = ent_w[DEPTH-1].vld;
  assign empty  = !ent_w[0].vld;
  assign found  = |eq_v;

  always_comb begin
    exact_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      exact_data = exact_data | taken_w[i];
    end
  end

  always_comb begin
    cmd.key       = in_item.prio_key;
    cmd.data      = in_item.entry_data;
    cmd.push      = 1'b0;
    cmd.pop_head  = 1'b0;
    cmd.pop_exact = 1'b0;
    res_nxt.status       = ST_OK;
    res_nxt.out_data     = '0;
    res_nxt.out_priority = '0;
    cnt_nxt = cnt_r;
    if (accept) begin
      case (in_item.kind)
        KIND_PUSH: begin
          if (full) begin
            res_nxt.status = ST_FULL;
          end else begin
            cmd.push = 1'b1;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        KIND_POP_HEAD, KIND_POP_MIN: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else if (in_item.kind == KIND_POP_MIN && !ge_v[0]) begin
            res_nxt.status = ST_NOT_FOUND;
          end else begin
            cmd.pop_head         = 1'b1;
            res_nxt.out_data     = ent_w[0].data;
            res_nxt.out_priority = ent_w[0].prio;
            cnt_nxt              = cnt_r - CNT_W'(1);
          end
        end
        KIND_POP_EXACT: begin
          if (empty) begin
            res_nxt.status = ST_EMPTY;
          end else if (!found) begin
            res_nxt.status = ST_NOT_FOUND;
          end else begin
            cmd.pop_exact        = 1'b1;
            res_nxt.out_data     = exact_data;
            res_nxt.out_priority = in_item.prio_key;
            cnt_nxt              = cnt_r - CNT_W'(1);
          end
        end
        default: begin
          res_nxt.status = ST_OK;
        end
      endcase
    end
    res_nxt.fill_count = FILL_W'(cnt_nxt);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_ge;
    logic   left_eq;

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_ge  = 1'b1;
      assign left_eq  = 1'b0;
    end else begin : g_inner
      assign left_ent = ent_w[i-1];
      assign left_ge  = ge_v[i-1];
      assign left_eq  = eq_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid
      assign right_ent = ent_w[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_ent   (left_ent),
      .left_ge    (left_ge),
      .left_eq    (left_eq),
      .right_ent  (right_ent),
      .ent        (ent_w[i]),
      .ge_key     (ge_v[i]),
      .eq_key     (eq_v[i]),
      .taken_data (taken_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      out_strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_result_r <= res_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule
